// ===== hw/rtl/sm3_pkg.sv =====
// shared types, constants and round functions for the sm3 hash engine
`default_nettype none
package sm3_pkg;

   localparam int unsigned NumRounds = 64;

   localparam logic [31:0] TLow  = 32'h79CC4519;
   localparam logic [31:0] THigh = 32'h7A879D8A;

   localparam logic [255:0] InitValue =
      256'h7380166F4914B2B9172442D7DA8A0600A96F30BC163138AAE38DEE4DB0FB0E4E;

   localparam logic [7:0] PadByte = 8'h80;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_START,
      ST_COMP,
      ST_DONE,
      ST_PAD,
      ST_PAD2,
      ST_OUT
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic put_byte;
      logic put_pad;
      logic clear_tail;
      logic clear_all;
      logic put_length;
      logic start_comp;
      logic round_step;
      logic finish_comp;
      logic reset_msg;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic [5:0] byte_pos;
      logic       last_round;
   } status_type;

   function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
      logic [63:0] d;
      d = {x, x} << n;
      return d[63:32];
   endfunction

   function automatic logic [31:0] perm0(input logic [31:0] x);
      return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
   endfunction

   function automatic logic [31:0] perm1(input logic [31:0] x);
      return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/sm3_if.sv =====
// valid/ready channel interfaces for message requests and digest words
`default_nettype none
interface sm3_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       byte_valid;
   logic       last_byte;
   modport source (output valid, data_byte, byte_valid, last_byte, input ready);
   modport sink   (input valid, data_byte, byte_valid, last_byte, output ready);
endinterface

interface sm3_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;
   modport source (output valid, digest_word, word_index, last_word, input ready);
   modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/sm3_datapath.sv =====
// sm3 datapath: block buffer, expansion window, round logic and chaining value
`default_nettype none
module sm3_datapath (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire sm3_pkg::cmd_type cmd,
   input  wire logic [7:0]       data_byte,
   input  wire logic [2:0]       out_sel,
   output sm3_pkg::status_type   status,
   output logic [31:0]           out_word
);

   logic [31:0] buf_ff [16];
   logic [31:0] win_ff [16];
   logic [31:0] r_ff   [8];
   logic [31:0] cv_ff  [8];
   logic [63:0] len_ff, len_in;
   logic [5:0]  pos_ff, pos_in;
   logic [5:0]  rnd_ff, rnd_in;

   logic [31:0] w_new, wj, wpj, t_j, a12, ss1, ss2, ff, gg, tt1, tt2, w4;
   logic [3:0]  j4, k4;

   assign j4 = rnd_ff[3:0];
   assign k4 = j4 + 4'd4;

   // W[j+4] from the window, only once the first sixteen words are used up
   assign w_new = sm3_pkg::perm1(win_ff[j4 - 4'd12] ^ win_ff[j4 - 4'd5]
                     ^ sm3_pkg::rotl(win_ff[j4 + 4'd1], 5'd15))
                  ^ sm3_pkg::rotl(win_ff[j4 - 4'd9], 5'd7) ^ win_ff[j4 - 4'd2];
   assign w4  = (rnd_ff >= 6'd12) ? w_new : win_ff[k4];
   assign wj  = win_ff[j4];
   assign wpj = wj ^ w4;
   assign t_j = (rnd_ff < 6'd16) ? sm3_pkg::TLow : sm3_pkg::THigh;
   assign a12 = sm3_pkg::rotl(r_ff[0], 5'd12);
   assign ss1 = sm3_pkg::rotl(a12 + r_ff[4] + sm3_pkg::rotl(t_j, rnd_ff[4:0]), 5'd7);
   assign ss2 = ss1 ^ a12;
   always_comb begin
      if (rnd_ff < 6'd16) begin
         ff = r_ff[0] ^ r_ff[1] ^ r_ff[2];
         gg = r_ff[4] ^ r_ff[5] ^ r_ff[6];
      end else begin
         ff = (r_ff[0] & r_ff[1]) | (r_ff[0] & r_ff[2]) | (r_ff[1] & r_ff[2]);
         gg = (r_ff[4] & r_ff[5]) | (~r_ff[4] & r_ff[6]);
      end
   end
   assign tt1 = ff + r_ff[3] + ss2 + wpj;
   assign tt2 = gg + r_ff[7] + ss1 + wj;

   always_comb begin
      len_in = len_ff;
      pos_in = pos_ff;
      rnd_in = rnd_ff;
      if (cmd.put_byte) begin
         len_in = len_ff + 64'd8;
         pos_in = pos_ff + 6'd1;
      end
      if (cmd.start_comp) rnd_in = '0;
      if (cmd.round_step) rnd_in = rnd_ff + 6'd1;
      if (cmd.reset_msg) begin
         len_in = '0;
         pos_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
         pos_ff <= '0;
         rnd_ff <= '0;
      end else begin
         len_ff <= len_in;
         pos_ff <= pos_in;
         rnd_ff <= rnd_in;
      end
   end

   // block buffer, length words left to put_length when both are asked
   always_ff @(posedge clock) begin
      if (cmd.put_byte || cmd.put_pad) begin
         logic [7:0]  b;
         logic [3:0]  wi;
         logic [4:0]  sh;
         b  = cmd.put_byte ? data_byte : sm3_pkg::PadByte;
         wi = pos_ff[5:2];
         sh = 5'd24 - {pos_ff[1:0], 3'd0};
         if (pos_ff[1:0] == 2'd0) buf_ff[wi] <= {24'd0, b} << sh;
         else                     buf_ff[wi] <= buf_ff[wi] | ({24'd0, b} << sh);
      end
      if (cmd.clear_tail) begin
         for (int i = 0; i < 16; i++)
            if (4'(i) > pos_ff[5:2] && !(cmd.put_length && i >= 14)) buf_ff[i] <= '0;
      end
      if (cmd.clear_all) begin
         for (int i = 0; i < 16; i++)
            if (!(cmd.put_length && i >= 14)) buf_ff[i] <= '0;
      end
      if (cmd.put_length) begin
         buf_ff[14] <= len_ff[63:32];
         buf_ff[15] <= len_ff[31:0];
      end
   end

   // window and working registers
   always_ff @(posedge clock) begin
      if (cmd.start_comp) begin
         for (int i = 0; i < 16; i++) win_ff[i] <= buf_ff[i];
         for (int i = 0; i < 8; i++)  r_ff[i]   <= cv_ff[i];
      end else if (cmd.round_step) begin
         if (rnd_ff >= 6'd12) win_ff[k4] <= w_new;
         r_ff[3] <= r_ff[2];
         r_ff[2] <= sm3_pkg::rotl(r_ff[1], 5'd9);
         r_ff[1] <= r_ff[0];
         r_ff[0] <= tt1;
         r_ff[7] <= r_ff[6];
         r_ff[6] <= sm3_pkg::rotl(r_ff[5], 5'd19);
         r_ff[5] <= r_ff[4];
         r_ff[4] <= sm3_pkg::perm0(tt2);
      end
   end

   // chaining value
   always_ff @(posedge clock) begin
      if (reset || cmd.reset_msg) begin
         for (int i = 0; i < 8; i++)
            cv_ff[i] <= sm3_pkg::InitValue[255 - 32*i -: 32];
      end else if (cmd.finish_comp) begin
         for (int i = 0; i < 8; i++) cv_ff[i] <= cv_ff[i] ^ r_ff[i];
      end
   end

   assign status.byte_pos   = pos_ff;
   assign status.last_round = (rnd_ff == 6'(sm3_pkg::NumRounds - 1));
   assign out_word          = cv_ff[out_sel];

endmodule
`default_nettype wire

// ===== hw/rtl/sm3_ctrl.sv =====
// sm3 controller: request intake, padding sequence, rounds and digest output
`default_nettype none
module sm3_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   sm3_req_if.sink                 req,
   input  wire logic               rsp_ready,
   output logic                    rsp_valid,
   output logic [2:0]              out_sel,
   output logic                    out_last,
   input  wire sm3_pkg::status_type status,
   output sm3_pkg::cmd_type        cmd
);

   sm3_pkg::state_type state_ff, state_in, ret_ff, ret_in;
   logic [2:0] sel_ff, sel_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sm3_pkg::ST_LOAD;
         ret_ff   <= sm3_pkg::ST_LOAD;
         sel_ff   <= '0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         sel_ff   <= sel_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      ret_in    = ret_ff;
      sel_in    = sel_ff;
      cmd       = '0;
      req.ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         sm3_pkg::ST_LOAD: begin
            req.ready = 1'b1;
            if (req.valid) begin
               cmd.put_byte = req.byte_valid;
               if (req.byte_valid && status.byte_pos == 6'd63) begin
                  // block full: the last byte is written into the buffer, then ST_START loads the block
                  state_in = sm3_pkg::ST_START;
                  ret_in   = req.last_byte ? sm3_pkg::ST_PAD : sm3_pkg::ST_LOAD;
               end else if (req.last_byte) begin
                  state_in = sm3_pkg::ST_PAD;
               end
            end
         end
         sm3_pkg::ST_PAD: begin
            cmd.put_pad    = 1'b1;
            cmd.clear_tail = 1'b1;
            state_in       = sm3_pkg::ST_START;
            if (status.byte_pos >= 6'd56) begin
               // no room for the length, it goes in a block of its own
               ret_in = sm3_pkg::ST_PAD2;
            end else begin
               cmd.put_length = 1'b1;
               ret_in         = sm3_pkg::ST_OUT;
            end
         end
         sm3_pkg::ST_PAD2: begin
            cmd.clear_all  = 1'b1;
            cmd.put_length = 1'b1;
            ret_in   = sm3_pkg::ST_OUT;
            state_in = sm3_pkg::ST_START;
         end
         sm3_pkg::ST_START: begin
            cmd.start_comp = 1'b1;
            state_in       = sm3_pkg::ST_COMP;
         end
         sm3_pkg::ST_COMP: begin
            cmd.round_step = 1'b1;
            if (status.last_round) state_in = sm3_pkg::ST_DONE;
         end
         sm3_pkg::ST_DONE: begin
            // fold the finished working registers into the chaining value
            cmd.finish_comp = 1'b1;
            sel_in   = '0;
            state_in = ret_ff;
         end
         sm3_pkg::ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               sel_in = sel_ff + 3'd1;
               if (sel_ff == 3'd7) begin
                  cmd.reset_msg = 1'b1;
                  ret_in   = sm3_pkg::ST_LOAD;
                  state_in = sm3_pkg::ST_LOAD;
               end
            end
         end
         default: state_in = sm3_pkg::ST_LOAD;
      endcase
   end

   assign out_sel  = sel_ff;
   assign out_last = (sel_ff == 3'd7);

   property p_no_req_busy;
      @(posedge clock) disable iff (reset)
         state_ff != sm3_pkg::ST_LOAD |-> !req.ready;
   endproperty
   a_no_req_busy: assert property (p_no_req_busy) else $error("request taken while busy");

   a_out_entry: assert property (@(posedge clock) disable iff (reset)
      state_ff == sm3_pkg::ST_OUT && $past(state_ff) != sm3_pkg::ST_OUT
      |-> $past(state_ff) == sm3_pkg::ST_DONE)
      else $error("digest without compression");

   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(sel_ff))
      else $error("digest word dropped");

endmodule
`default_nettype wire

// ===== hw/rtl/sm3_hash_engine.sv =====
// top level of the sm3 hash engine
// message end: a padding step and one compression follow the ending request, two with long
// padding, one more when the ending request also completes a block; then 8 digest words
// throughput: one request per cycle while filling; no request is taken while a 64-byte
// block is loaded into the window, run through the rounds and folded into the chaining value
// reset: synchronous, restores the standard initial value, zero length and byte position
`default_nettype none
module sm3_hash_engine (
   input  wire logic clock,
   input  wire logic reset,
   sm3_req_if.sink   req,
   sm3_rsp_if.source rsp
);

   sm3_pkg::cmd_type    cmd;
   sm3_pkg::status_type status;
   logic [2:0]          out_sel;
   logic                out_last;
   logic [31:0]         out_word;

   // sequencing of requests, padding and compressions
   sm3_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .rsp_ready (rsp.ready),
      .rsp_valid (rsp.valid),
      .out_sel   (out_sel),
      .out_last  (out_last),
      .status    (status),
      .cmd       (cmd)
   );

   // storage and round function
   sm3_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .data_byte (req.data_byte),
      .out_sel   (out_sel),
      .status    (status),
      .out_word  (out_word)
   );

   // digest words straight from the chaining value
   assign rsp.digest_word = out_word;
   assign rsp.word_index  = out_sel;
   assign rsp.last_word   = out_last;

endmodule
`default_nettype wire
